/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of the dilation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define BDIL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define BDIL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/bdil_pkg.sv */
// Shared constants, types and helpers of the 3x3 binary dilation block.
`timescale 1ns / 1ps
package bdil_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_W    = CFG_W;
    localparam int ROW_W     = SIZE_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int LINE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [PIX_W-1:0]  THRESH_RESET = 8'd127;
    localparam logic [PIX_W-1:0]  PIX_ON       = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_OFF      = 8'd0;
    localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FEED0,
        KIND_FEEDX,
        KIND_TAIL
    } t_s1_kind;

    typedef struct packed {
        t_s1_kind         kind;
        logic             wr;
        logic [COL_W-1:0] addr;
        logic             lit;
        logic             use_up;
        logic             emit;
        logic             rend;
        logic             fend;
        logic             use_w2;
        logic             w_ge2;
    } t_s1_ctrl;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                      input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bdil_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module bdil_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/binary_dilation_3x3_core.sv */
// Top level of the streaming 3x3 binary dilation block.
// The line RAM has separate read and write ports; a beat passes the stage-1 register
// and then the output register. Throughput: one beat per cycle unless the output stalls.
// Reset clears counters, window and handshake state and sets config to its defaults.
// The line RAM is not cleared; no frame uses an entry before writing it.
`timescale 1ns / 1ps
module binary_dilation_3x3_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdil_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdil_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [bdil_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bdil_pkg::PIX_W-1:0]     o_out_value,
    output logic                           o_row_end,
    output logic                           o_frame_end
);
    import bdil_pkg::*;

    logic [SIZE_W-1:0] r_eff_w;
    logic [SIZE_W-1:0] r_eff_h;
    logic [PIX_W-1:0]  r_thresh;

    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    logic              r_s1_valid;
    t_s1_ctrl          r_s1, n_s1;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [2:0]        r_win, n_win;

    logic              r_o_valid;
    logic [PIX_W-1:0]  r_o_value;
    logic              r_o_row_end;
    logic              r_o_frame_end;

    logic              in_acc;
    logic              s0_feed;
    logic [SIZE_W:0]   w_ext;
    logic [SIZE_W:0]   in_col_inc;
    logic [SIZE_W:0]   in_row_inc;
    logic [SIZE_W:0]   out_col_ext;
    logic [SIZE_W:0]   out_col_inc;
    logic [SIZE_W:0]   out_row_inc;

    logic              s1_go;
    logic              s1_fire;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] s1_lines;
    logic              s1_colv;
    logic [2:0]        s1_shift;
    logic              s1_tail_val;
    logic              s1_val;
    logic              ram_we;
    logic [LINE_W-1:0] ram_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w  <= WIDTH_LIMIT;
            r_eff_h  <= HEIGHT_LIMIT;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_eff_w  <= clamp_size(i_cfg_data, WIDTH_LIMIT);
                CFG_IDX_HEIGHT: r_eff_h  <= clamp_size(i_cfg_data, HEIGHT_LIMIT);
                CFG_IDX_THRESH: r_thresh <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_go      = !r_o_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    assign w_ext       = {1'b0, r_eff_w};
    assign in_col_inc  = {{(SIZE_W + 1 - COL_W){1'b0}}, r_in_col} + (SIZE_W + 1)'(1);
    assign in_row_inc  = {1'b0, r_in_row} + (SIZE_W + 1)'(1);
    assign out_col_ext = {{(SIZE_W + 1 - COL_W){1'b0}}, r_out_col};
    assign out_col_inc = out_col_ext + (SIZE_W + 1)'(1);
    assign out_row_inc = {1'b0, r_out_row} + (SIZE_W + 1)'(1);

    always_comb begin
        n_s1      = '0;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        s0_feed   = 1'b0;
        if (i_opcode == OP_PIXEL) begin
            if (r_in_row < r_eff_h) begin
                n_s1.wr     = 1'b1;
                n_s1.addr   = r_in_col;
                n_s1.lit    = i_pixel_value > r_thresh;
                n_s1.use_up = r_in_row >= ROW_W'(2);
                s0_feed     = (r_in_row != '0) && (r_out_row < r_eff_h);
                if (in_col_inc >= w_ext) begin
                    n_in_col = '0;
                    n_in_row = in_row_inc[ROW_W-1:0];
                end else begin
                    n_in_col = in_col_inc[COL_W-1:0];
                end
            end
        end else if (r_in_row >= r_eff_h) begin
            if (r_out_row < r_eff_h) begin
                s0_feed     = 1'b1;
                n_s1.addr   = r_out_col;
                n_s1.use_up = r_eff_h >= SIZE_W'(2);
            end else begin
                n_s1.kind = KIND_TAIL;
                n_s1.emit = 1'b1;
                n_s1.rend = 1'b1;
                n_s1.fend = 1'b1;
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
        if (s0_feed) begin
            if (r_out_col == '0) begin
                n_s1.kind = KIND_FEED0;
                n_s1.emit = r_out_row != '0;
                n_s1.rend = 1'b1;
                n_s1.fend = r_out_row >= r_eff_h;
            end else begin
                n_s1.kind   = KIND_FEEDX;
                n_s1.emit   = 1'b1;
                n_s1.rend   = out_col_ext >= w_ext;
                n_s1.fend   = (out_col_ext >= w_ext) && (out_row_inc >= {1'b0, r_eff_h});
                n_s1.use_w2 = r_out_col != COL_W'(1);
            end
            if (out_col_inc >= w_ext) begin
                n_out_col = '0;
                n_out_row = out_row_inc[ROW_W-1:0];
            end else begin
                n_out_col = out_col_inc[COL_W-1:0];
            end
        end
        n_s1.w_ge2 = r_eff_w >= SIZE_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (in_acc) begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= 1'b1;
            r_fwd      <= ram_we && (r_s1.addr == n_s1.addr);
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1       <= n_s1;
            r_fwd_data <= ram_wdata;
        end
    end

    bdil_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.addr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (n_s1.addr),
        .o_rdata (ram_rdata)
    );

    // Bit 1 holds the row two back, bit 0 the row one back.
    assign s1_lines    = r_fwd ? r_fwd_data : ram_rdata;
    assign s1_colv     = r_s1.lit | s1_lines[0] | (r_s1.use_up & s1_lines[1]);
    assign s1_shift    = {r_win[1:0], s1_colv};
    assign s1_tail_val = r_win[0] | (r_s1.w_ge2 & r_win[1]);
    assign ram_we      = s1_fire && r_s1.wr;
    assign ram_wdata   = {s1_lines[0], r_s1.lit};

    always_comb begin
        n_win  = r_win;
        s1_val = 1'b0;
        case (r_s1.kind)
            KIND_NONE: ;
            KIND_FEED0: begin
                n_win  = s1_shift;
                s1_val = s1_tail_val;
            end
            KIND_FEEDX: begin
                n_win  = s1_shift;
                s1_val = s1_shift[0] | s1_shift[1] | (r_s1.use_w2 & s1_shift[2]);
            end
            KIND_TAIL: begin
                n_win  = '0;
                s1_val = s1_tail_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_win <= n_win;
            end
            if (s1_fire && r_s1.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.emit) begin
            r_o_value     <= s1_val ? PIX_ON : PIX_OFF;
            r_o_row_end   <= r_s1.rend;
            r_o_frame_end <= r_s1.fend;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_value = r_o_value;
    assign o_row_end   = r_o_row_end;
    assign o_frame_end = r_o_frame_end;

endmodule

/* hw/rtl/bdil_checker.sv */
// Port-level assertions for the dilation block and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdil_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [bdil_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [bdil_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_opcode,
    input logic [bdil_pkg::PIX_W-1:0]     i_pixel_value,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [bdil_pkg::PIX_W-1:0]     o_out_value,
    input logic                           o_row_end,
    input logic                           o_frame_end
);
    import bdil_pkg::*;

    `BDIL_ASSERT(a_value_binary, o_out_valid |-> (o_out_value == PIX_ON || o_out_value == PIX_OFF), "Output beat value is neither 0 nor 255.")
    `BDIL_ASSERT(a_frame_on_row, (o_out_valid && o_frame_end) |-> o_row_end, "Frame end flagged without row end.")
    `BDIL_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_value) && $stable(o_row_end) && $stable(o_frame_end)), "Stalled output beat changed.")
    `BDIL_ASSERT(a_ready_when_drained, !o_out_valid |-> o_in_ready, "Input stalled while output register is empty.")
    `BDIL_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "Output beat valid right after reset.")

endmodule

bind binary_dilation_3x3_core bdil_checker u_bdil_checker (.*);
